>>> rtl/core/remp_pkg.sv
// ----------------------------------------------------------------------------
// remp_pkg: shared types and constants
// Magnitude classes, table cell layout and mode codes.
// ----------------------------------------------------------------------------
package remp_pkg;

    localparam int DEF_MAX_LEN = 1024;
    localparam int DEF_LEVELS  = 11;
    localparam int LEN_W   = 11;
    localparam int VAL_W   = 31;
    localparam int MAG_W   = 31;
    localparam int ANS_W   = 61;
    localparam int CELL_W  = 2 * (2 * MAG_W + 1);

    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic CFG_LEN_FIRST  = 1'b0;
    localparam logic CFG_LEN_SECOND = 1'b1;

    typedef struct packed {
        logic             any;
        logic [MAG_W-1:0] lo;
        logic [MAG_W-1:0] hi;
    } mag_cls_t;

    // c0: non-positive class, c1: non-negative class
    typedef struct packed {
        mag_cls_t c0;
        mag_cls_t c1;
    } cell_t;

    function automatic mag_cls_t merge_cls(mag_cls_t a, mag_cls_t b);
        mag_cls_t r;
        if (!a.any)
            r = b;
        else if (!b.any)
            r = a;
        else
        begin
            r.any = 1'b1;
            r.lo  = (a.lo < b.lo) ? a.lo : b.lo;
            r.hi  = (a.hi > b.hi) ? a.hi : b.hi;
        end
        return r;
    endfunction

    function automatic cell_t merge_cell(cell_t a, cell_t b);
        cell_t r;
        r.c0 = merge_cls(a.c0, b.c0);
        r.c1 = merge_cls(a.c1, b.c1);
        return r;
    endfunction

    function automatic cell_t leaf(logic [VAL_W-1:0] v);
        cell_t e;
        e = '0;
        if (v[VAL_W-1])
        begin
            e.c0.any = 1'b1;
            e.c0.lo  = MAG_W'(32'h8000_0000 - {1'b0, v});
            e.c0.hi  = e.c0.lo;
        end
        else if (v != '0)
        begin
            e.c1.any = 1'b1;
            e.c1.lo  = v;
            e.c1.hi  = v;
        end
        else
        begin
            e.c0.any = 1'b1;
            e.c1.any = 1'b1;
        end
        return e;
    endfunction

endpackage

>>> rtl/core/remp_ram.sv
// ----------------------------------------------------------------------------
// remp_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module remp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

>>> rtl/core/remp_mul.sv
// ----------------------------------------------------------------------------
// remp_mul: shared signed multiplier
// Registered 32x32 product used for every candidate pair.
// ----------------------------------------------------------------------------
module remp_mul (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] p_reg
);

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule

>>> rtl/core/range_extremum_minimax_product_top.sv
// ----------------------------------------------------------------------------
// range_extremum_minimax_product_top: sparse-table min/max product query
// Two arrays of signed words; range query returns max-min product.
// ----------------------------------------------------------------------------
// Usage:
//   start/busy command channel carries mode, load_index, load_value and the
//   two query ranges. A word is taken when start is high and busy is low.
//   Loads give no result. A query gives one answer word,
//   flagged by done for one cycle; the receiver cannot stall it.
//   A query passes a check step, table reads on the single RAM port of each
//   store, eight products through one shared multiplier, a saturate step and
//   a result step.
//   The first query after reset or after any load with a valid index first
//   rebuilds both sparse tables, each cell from two reads of level j-1 and
//   one write, MAX_LEN-2^j+1 cells on level j.
//   Invalid queries and mode 3 finish with no result.
//   cfg_we/cfg_index/cfg_data write len_first (0) and len_second (1).
//   Reset clears control state and lengths to 1; table contents are
//   undefined until loaded.
// ----------------------------------------------------------------------------
module range_extremum_minimax_product_top
    import remp_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN,
    parameter int LEVELS  = DEF_LEVELS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              mode,
    input  logic [LEN_W-1:0]        load_index,
    input  logic signed [VAL_W-1:0] load_value,
    input  logic [LEN_W-1:0]        first_lo,
    input  logic [LEN_W-1:0]        first_hi,
    input  logic [LEN_W-1:0]        second_lo,
    input  logic [LEN_W-1:0]        second_hi,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [LEN_W-1:0]        cfg_data,
    output logic                    done,
    output logic signed [ANS_W-1:0] answer
);

    localparam int IW    = $clog2(MAX_LEN);
    localparam int LW    = $clog2(LEVELS);
    localparam int DEPTH = LEVELS * MAX_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = IW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_RB_RD0, S_RB_RD1, S_RB_WR, S_Q_RD0, S_Q_RD1, S_Q_RD2,
        S_Q_MUL, S_Q_ACC, S_DONE
    } state_t;

    state_t state_reg;
    logic current_reg;
    logic [LEN_W-1:0] len_a_reg, len_b_reg;
    logic [1:0] mode_reg;
    logic [LEN_W-1:0] l1_reg, r1_reg, l2_reg, r2_reg;
    logic [LW-1:0] lvl_reg;
    logic [CW-1:0] pos_reg;
    logic [LW-1:0] ka_reg, kb_reg;
    cell_t ra_reg, rb_reg;
    logic [2:0] pair_reg;
    logic signed [63:0] cur_reg, best_reg;
    logic got_reg, have_reg;
    logic done_reg;
    logic signed [ANS_W-1:0] answer_reg;

    logic we_a, we_b;
    logic [AW-1:0] addr_a, addr_b;
    cell_t wdata_a, wdata_b, rdata_a, rdata_b;

    remp_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram_a (
        .clk(clk), .we(we_a), .addr(addr_a), .wdata(wdata_a), .rdata(rdata_a));
    remp_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram_b (
        .clk(clk), .we(we_b), .addr(addr_b), .wdata(wdata_b), .rdata(rdata_b));

    function automatic logic [AW-1:0] tad(logic [LW-1:0] l, logic [IW-1:0] i);
        return AW'(AW'(l) * AW'(MAX_LEN) + AW'(i));
    endfunction

    function automatic logic [LW-1:0] lvl_of(logic [LEN_W-1:0] n);
        logic [LW-1:0] k;
        k = '0;
        for (int j = 1; j < LEVELS; j++)
            if ((32'(n) >> j) != 0)
                k = LW'(j);
        return k;
    endfunction

    logic [LEN_W-1:0] eff_a, eff_b;
    assign eff_a = (32'(len_a_reg) > MAX_LEN) ? LEN_W'(MAX_LEN) : len_a_reg;
    assign eff_b = (32'(len_b_reg) > MAX_LEN) ? LEN_W'(MAX_LEN) : len_b_reg;

    logic q_ok;
    assign q_ok = (l1_reg != 0) && (l1_reg <= r1_reg) && (r1_reg <= eff_a)
               && (l2_reg != 0) && (l2_reg <= r2_reg) && (r2_reg <= eff_b);

    logic [31:0] span;
    logic [31:0] half;
    assign span = 32'd1 << lvl_reg;
    assign half = span >> 1;

    logic [IW-1:0] ia1, ia2, ib1, ib2;
    assign ia1 = IW'(l1_reg - 1'b1);
    assign ia2 = IW'(32'(r1_reg) - (32'd1 << ka_reg));
    assign ib1 = IW'(l2_reg - 1'b1);
    assign ib2 = IW'(32'(r2_reg) - (32'd1 << kb_reg));

    logic ld_ok;
    assign ld_ok = (l1_reg != 0) && (32'(l1_reg) <= MAX_LEN);

    always_comb
    begin
        we_a = 1'b0;
        we_b = 1'b0;
        addr_a = tad(lvl_reg, IW'(pos_reg));
        addr_b = addr_a;
        wdata_a = merge_cell(ra_reg, rdata_a);
        wdata_b = merge_cell(rb_reg, rdata_b);
        case (state_reg)
            S_CHECK:
            begin
                if (mode_reg == MODE_LOAD_A || mode_reg == MODE_LOAD_B)
                begin
                    we_a = ld_ok && (mode_reg == MODE_LOAD_A);
                    we_b = ld_ok && (mode_reg == MODE_LOAD_B);
                    addr_a = tad('0, IW'(l1_reg - 1'b1));
                    addr_b = addr_a;
                    wdata_a = leaf(answer_reg[VAL_W-1:0]);
                    wdata_b = wdata_a;
                end
            end
            S_RB_RD0:
            begin
                addr_a = tad(LW'(lvl_reg - 1'b1), IW'(pos_reg));
                addr_b = addr_a;
            end
            S_RB_RD1:
            begin
                addr_a = tad(LW'(lvl_reg - 1'b1), IW'(32'(pos_reg) + half));
                addr_b = addr_a;
            end
            S_RB_WR:
            begin
                we_a = 1'b1;
                we_b = 1'b1;
            end
            S_Q_RD0:
            begin
                addr_a = tad(ka_reg, ia1);
                addr_b = tad(kb_reg, ib1);
            end
            S_Q_RD1:
            begin
                addr_a = tad(ka_reg, ia2);
                addr_b = tad(kb_reg, ib2);
            end
            default: ;
        endcase
    end

    // Candidate selection: pair[2:1] picks x, pair[2] and pair[0] pick y
    logic signed [31:0] mx, my;
    logic xv, yv;
    always_comb
    begin
        case (pair_reg[2:1])
            2'd0: begin mx = -$signed({1'b0, ra_reg.c0.hi}); xv = ra_reg.c0.any; end
            2'd1: begin mx = -$signed({1'b0, ra_reg.c0.lo}); xv = ra_reg.c0.any; end
            2'd2: begin mx = $signed({1'b0, ra_reg.c1.hi});  xv = ra_reg.c1.any; end
            default: begin mx = $signed({1'b0, ra_reg.c1.lo}); xv = ra_reg.c1.any; end
        endcase
        if (!pair_reg[2])
        begin
            if (!pair_reg[0])
            begin
                my = -$signed({1'b0, rb_reg.c0.lo}); yv = rb_reg.c0.any;
            end
            else
            begin
                my = $signed({1'b0, rb_reg.c1.hi}); yv = rb_reg.c1.any;
            end
        end
        else
        begin
            if (!pair_reg[0])
            begin
                my = $signed({1'b0, rb_reg.c1.lo}); yv = rb_reg.c1.any;
            end
            else
            begin
                my = -$signed({1'b0, rb_reg.c0.hi}); yv = rb_reg.c0.any;
            end
        end
    end

    logic signed [63:0] prod;
    remp_mul u_mul (.clk(clk), .a(mx), .b(my), .p_reg(prod));

    logic signed [63:0] cur_n;
    logic got_n;
    localparam logic signed [63:0] TOP = 64'sh0FFF_FFFF_FFFF_FFFF;
    always_comb
    begin
        cur_n = (xv && yv && (!pair_reg[0] || !got_reg || prod < cur_reg)) ? prod : cur_reg;
        got_n = (pair_reg[0] ? got_reg : 1'b0) || (xv && yv);
        if (!pair_reg[0] && xv && yv)
            cur_n = prod;
        else if (!pair_reg[0])
            cur_n = cur_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            current_reg <= 1'b0;
            len_a_reg   <= LEN_W'(1);
            len_b_reg   <= LEN_W'(1);
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == CFG_LEN_FIRST)
                    len_a_reg <= cfg_data;
                else
                    len_b_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg <= mode;
                        l1_reg <= (mode == MODE_QUERY) ? first_lo : load_index;
                        r1_reg <= first_hi;
                        l2_reg <= second_lo;
                        r2_reg <= second_hi;
                        answer_reg <= ANS_W'(load_value);
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    ka_reg <= lvl_of(LEN_W'(r1_reg - l1_reg + 1'b1));
                    kb_reg <= lvl_of(LEN_W'(r2_reg - l2_reg + 1'b1));
                    state_reg <= S_IDLE;
                    if (mode_reg == MODE_LOAD_A || mode_reg == MODE_LOAD_B)
                    begin
                        if (ld_ok)
                            current_reg <= 1'b0;
                    end
                    else if (mode_reg == MODE_QUERY && q_ok)
                    begin
                        if (!current_reg)
                        begin
                            lvl_reg <= LW'(1);
                            pos_reg <= '0;
                            state_reg <= S_RB_RD0;
                        end
                        else
                            state_reg <= S_Q_RD0;
                    end
                end
                S_RB_RD0: state_reg <= S_RB_RD1;
                S_RB_RD1:
                begin
                    ra_reg <= rdata_a;
                    rb_reg <= rdata_b;
                    state_reg <= S_RB_WR;
                end
                S_RB_WR:
                begin
                    if (32'(pos_reg) + span >= MAX_LEN)
                    begin
                        pos_reg <= '0;
                        if (32'(lvl_reg) + 1 >= LEVELS || (span << 1) > MAX_LEN)
                        begin
                            current_reg <= 1'b1;
                            state_reg <= S_Q_RD0;
                        end
                        else
                        begin
                            lvl_reg <= LW'(lvl_reg + 1'b1);
                            state_reg <= S_RB_RD0;
                        end
                    end
                    else
                    begin
                        pos_reg <= CW'(pos_reg + 1'b1);
                        state_reg <= S_RB_RD0;
                    end
                end
                S_Q_RD0: state_reg <= S_Q_RD1;
                S_Q_RD1:
                begin
                    ra_reg <= rdata_a;
                    rb_reg <= rdata_b;
                    state_reg <= S_Q_RD2;
                end
                S_Q_RD2:
                begin
                    ra_reg <= merge_cell(ra_reg, rdata_a);
                    rb_reg <= merge_cell(rb_reg, rdata_b);
                    pair_reg <= '0;
                    have_reg <= 1'b0;
                    got_reg <= 1'b0;
                    best_reg <= '0;
                    state_reg <= S_Q_MUL;
                end
                S_Q_MUL: state_reg <= S_Q_ACC;
                S_Q_ACC:
                begin
                    cur_reg <= cur_n;
                    got_reg <= got_n;
                    if (pair_reg[0])
                    begin
                        if (got_n && (!have_reg || cur_n > best_reg))
                        begin
                            best_reg <= cur_n;
                            have_reg <= 1'b1;
                        end
                    end
                    if (pair_reg == 3'd7)
                        state_reg <= S_DONE;
                    else
                    begin
                        pair_reg <= pair_reg + 1'b1;
                        state_reg <= S_Q_MUL;
                    end
                end
                S_DONE:
                begin
                    answer_reg <= (best_reg > TOP) ? ANS_W'(TOP) : ANS_W'(best_reg);
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign answer = answer_reg;

endmodule

>>> rtl/core/remp_checker.sv
// ----------------------------------------------------------------------------
// remp_checker: port-level checks
// Watches the command and result ports of the top level.
// ----------------------------------------------------------------------------
module remp_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("busy with result");

endmodule

bind range_extremum_minimax_product_top remp_checker u_remp_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done));

>>> verif/tb_range_extremum_minimax_product_top.sv
// ----------------------------------------------------------------------------
// tb_range_extremum_minimax_product_top: self-checking bench for the
// sparse-table min/max product query block.
// Loads both arrays, sweeps the length registers and issues range queries.
// Every answer word is checked against a behavioral predictor that scans each
// range directly. Load and query words are mixed with invalid queries, bad
// load indexes and the unused mode. Valid queries only cover positions that
// have been loaded.
// ----------------------------------------------------------------------------
module tb_range_extremum_minimax_product_top;
    import remp_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         MAXLEN      = DEF_MAX_LEN;
    localparam int         PREFIX      = 160;
    localparam longint     CYCLE_LIMIT = 3000000;
    localparam longint     ANS_TOP     = (64'sd1 <<< 60) - 1;

    typedef struct {
        bit     any;
        longint lo;
        longint hi;
    } mag_range_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              mode;
    logic [LEN_W-1:0]        load_index;
    logic signed [VAL_W-1:0] load_value;
    logic [LEN_W-1:0]        first_lo;
    logic [LEN_W-1:0]        first_hi;
    logic [LEN_W-1:0]        second_lo;
    logic [LEN_W-1:0]        second_hi;
    logic                    cfg_we;
    logic                    cfg_index;
    logic [LEN_W-1:0]        cfg_data;
    logic                    done;
    logic signed [ANS_W-1:0] answer;

    logic [VAL_W-1:0] elem_val [2][1:MAXLEN];
    bit               elem_set [2][1:MAXLEN];
    int unsigned      len_reg [2];
    longint           answer_queue[$];
    int               errors;
    longint           cycles;

    range_extremum_minimax_product_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .load_index(load_index), .load_value(load_value),
        .first_lo(first_lo), .first_hi(first_hi),
        .second_lo(second_lo), .second_hi(second_hi),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .answer(answer)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    function automatic int unsigned eff_len(input int unsigned len);
        return (len > MAXLEN) ? MAXLEN : len;
    endfunction

    function automatic bit query_valid(input int l1, input int h1, input int l2, input int h2);
        return l1 != 0 && l1 <= h1 && h1 <= eff_len(len_reg[0]) &&
               l2 != 0 && l2 <= h2 && h2 <= eff_len(len_reg[1]);
    endfunction

    function automatic bit range_loaded(input int arr, input int lo, input int hi);
        for (int i = lo; i <= hi; i++)
            if (!elem_set[arr][i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void widen(inout mag_range_t r, input longint m);
        if (!r.any || m < r.lo)
            r.lo = m;
        if (!r.any || m > r.hi)
            r.hi = m;
        r.any = 1'b1;
    endfunction

    // neg: non-positive class, pos: non-negative class; zero is in both
    function automatic void scan_classes(input int arr, input int lo, input int hi,
                                         output mag_range_t neg, output mag_range_t pos);
        logic [VAL_W-1:0] v;
        neg = '{0, 0, 0};
        pos = '{0, 0, 0};
        for (int i = lo; i <= hi; i++)
        begin
            v = elem_val[arr][i];
            if (v[VAL_W-1])
                widen(neg, 64'sh8000_0000 - longint'(v));
            else if (v != '0)
                widen(pos, longint'(v));
            else
            begin
                widen(neg, 0);
                widen(pos, 0);
            end
        end
    endfunction

    function automatic void best_min_product(input longint x, input bit from_pos,
                                             input mag_range_t bneg, input mag_range_t bpos,
                                             inout longint best, inout bit have);
        longint now;
        bit     got;
        now = 0;
        got = 1'b0;
        if (!from_pos)
        begin
            if (bneg.any) begin now = x * -bneg.lo; got = 1'b1; end
            if (bpos.any && (!got || x * bpos.hi < now)) now = x * bpos.hi;
            got = got | bpos.any;
        end
        else
        begin
            if (bpos.any) begin now = x * bpos.lo; got = 1'b1; end
            if (bneg.any && (!got || x * -bneg.hi < now)) now = x * -bneg.hi;
            got = got | bneg.any;
        end
        if (got && (!have || now > best))
        begin
            best = now;
            have = 1'b1;
        end
    endfunction

    function automatic longint minimax_answer(input int l1, input int h1,
                                              input int l2, input int h2);
        mag_range_t aneg, apos, bneg, bpos;
        longint     best;
        bit         have;
        best = 0;
        have = 1'b0;
        scan_classes(0, l1, h1, aneg, apos);
        scan_classes(1, l2, h2, bneg, bpos);
        if (aneg.any)
        begin
            best_min_product(-aneg.hi, 1'b0, bneg, bpos, best, have);
            best_min_product(-aneg.lo, 1'b0, bneg, bpos, best, have);
        end
        if (apos.any)
        begin
            best_min_product(apos.hi, 1'b1, bneg, bpos, best, have);
            best_min_product(apos.lo, 1'b1, bneg, bpos, best, have);
        end
        return (best > ANS_TOP) ? ANS_TOP : best;
    endfunction

    task automatic send_word(input logic [1:0] m, input int idx, input logic [VAL_W-1:0] val,
                             input int l1, input int h1, input int l2, input int h2);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= m;
        load_index <= LEN_W'(idx);
        load_value <= val;
        first_lo   <= LEN_W'(l1);
        first_hi   <= LEN_W'(h1);
        second_lo  <= LEN_W'(l2);
        second_hi  <= LEN_W'(h2);
        do
            @(posedge clk);
        while (busy);
        if ((m == MODE_LOAD_A || m == MODE_LOAD_B) && idx >= 1 && idx <= MAXLEN)
        begin
            elem_val[m[0]][idx] = val;
            elem_set[m[0]][idx] = 1'b1;
        end
        else if (m == MODE_QUERY && query_valid(l1, h1, l2, h2))
            answer_queue.push_back(minimax_answer(l1, h1, l2, h2));
    endtask

    task automatic load_word(input logic [1:0] m, input int idx, input logic [VAL_W-1:0] val);
        send_word(m, idx, val, $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 2047), $urandom_range(0, 2047));
    endtask

    task automatic query_word(input int l1, input int h1, input int l2, input int h2);
        send_word(MODE_QUERY, $urandom_range(0, 2047), VAL_W'($urandom), l1, h1, l2, h2);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (answer_queue.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_lengths(input int len_a, input int len_b);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LEN_FIRST;
        cfg_data  <= LEN_W'(len_a);
        @(posedge clk);
        cfg_index <= CFG_LEN_SECOND;
        cfg_data  <= LEN_W'(len_b);
        @(posedge clk);
        cfg_we    <= 1'b0;
        len_reg[0] = len_a & 11'h7FF;
        len_reg[1] = len_b & 11'h7FF;
    endtask

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 31'h4000_0000;
            2: return 31'h3FFF_FFFF;
            3: return VAL_W'($urandom_range(0, 40) - 20);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic test_reset_lengths();
        load_word(MODE_LOAD_A, 1, 31'h4000_0000);
        load_word(MODE_LOAD_B, 1, 31'h4000_0000);
        query_word(1, 1, 1, 1);
        query_word(1, 2, 1, 1);
    endtask

    task automatic test_directed_queries();
        logic [VAL_W-1:0] a_vals [8];
        logic [VAL_W-1:0] b_vals [8];
        a_vals = '{31'h4000_0000, 31'h3FFF_FFFF, 0, -1, 1, -1000000000, 1000000000, 5};
        b_vals = '{3, 7, 31'h3FFF_FFFF, -2, -9, 0, 31'h4000_0000, 1};
        for (int i = 0; i < 8; i++)
        begin
            load_word(MODE_LOAD_A, i + 1, a_vals[i]);
            load_word(MODE_LOAD_B, i + 1, b_vals[i]);
        end
        set_lengths(8, 8);
        query_word(1, 8, 1, 8);
        query_word(7, 7, 1, 3);
        query_word(1, 1, 4, 5);
        query_word(3, 3, 6, 6);
        query_word(2, 2, 7, 7);
        query_word(4, 6, 2, 5);
    endtask

    task automatic test_ignored_words();
        load_word(MODE_LOAD_A, 0, 31'h7FFF_FFFF);
        load_word(MODE_LOAD_B, 1025, 31'h1234);
        load_word(MODE_LOAD_A, 2047, 31'h5555_5555);
        send_word(MODE_UNUSED, 1, 31'h1, 1, 1, 1, 1);
        query_word(0, 3, 1, 1);
        query_word(4, 3, 1, 1);
        query_word(1, 9, 1, 1);
        query_word(1, 1, 2, 2047);
        query_word(2, 2, 2, 2);
        set_lengths(0, 2047);
        query_word(1, 1, 1, 1);
        set_lengths(1024, 0);
        query_word(1, 1, 1, 1);
    endtask

    task automatic test_random_phases();
        int l1, h1, l2, h2, lim_a, lim_b, pick;
        for (int i = 1; i <= PREFIX; i++)
        begin
            load_word(MODE_LOAD_A, i, random_value());
            load_word(MODE_LOAD_B, i, random_value());
        end
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase % 4)
                0: set_lengths(PREFIX, PREFIX);
                1: set_lengths(1024, 2047);
                2: set_lengths($urandom_range(1, PREFIX), $urandom_range(1, PREFIX));
                default: set_lengths(1, $urandom_range(1, 2047));
            endcase
            repeat (25)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_word(MODE_UNUSED, $urandom_range(0, 2047), VAL_W'($urandom),
                              1, 1, 1, 1);
                else if (pick == 1)
                    load_word(MODE_LOAD_A, $urandom_range(0, 2047), random_value());
                else
                    load_word(pick[0] ? MODE_LOAD_A : MODE_LOAD_B,
                              $urandom_range(1, PREFIX), random_value());
            end
            lim_a = eff_len(len_reg[0]) < PREFIX ? eff_len(len_reg[0]) : PREFIX;
            lim_b = eff_len(len_reg[1]) < PREFIX ? eff_len(len_reg[1]) : PREFIX;
            repeat (100)
            begin
                do
                begin
                    if ($urandom_range(0, 3) != 0 && lim_a > 0 && lim_b > 0)
                    begin
                        l1 = $urandom_range(1, lim_a);
                        h1 = $urandom_range(0, 1) ? l1 + $urandom_range(0, 3)
                                                  : $urandom_range(l1, lim_a);
                        l2 = $urandom_range(1, lim_b);
                        h2 = $urandom_range(0, 1) ? l2 + $urandom_range(0, 3)
                                                  : $urandom_range(l2, lim_b);
                        if (h1 > lim_a) h1 = lim_a;
                        if (h2 > lim_b) h2 = lim_b;
                    end
                    else
                    begin
                        l1 = $urandom_range(0, 2047);
                        h1 = $urandom_range(0, 2047);
                        l2 = $urandom_range(0, 2047);
                        h2 = $urandom_range(0, 2047);
                    end
                end
                while (query_valid(l1, h1, l2, h2) &&
                       !(range_loaded(0, l1, h1) && range_loaded(1, l2, h2)));
                query_word(l1, h1, l2, h2);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (done)
        begin
            if (answer_queue.size() == 0)
                report($sformatf("answer %0d with no query pending", answer));
            else if (answer !== ANS_W'(answer_queue[0]))
            begin
                report($sformatf("answer %0d, expected %0d", answer, answer_queue[0]));
                void'(answer_queue.pop_front());
            end
            else
                void'(answer_queue.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_range_extremum_minimax_product_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        errors     = 0;
        cycles     = 0;
        len_reg    = '{1, 1};
        rst_n      = 1'b0;
        start      = 1'b0;
        mode       = MODE_LOAD_A;
        load_index = '0;
        load_value = '0;
        first_lo   = '0;
        first_hi   = '0;
        second_lo  = '0;
        second_hi  = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_LEN_FIRST;
        cfg_data   = '0;
        foreach (elem_set[a, i])
            elem_set[a][i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_lengths();
        test_directed_queries();
        test_ignored_words();
        test_random_phases();
        start <= 1'b0;
        while (answer_queue.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb_range_extremum_minimax_product_top: done, clean");
        else
            $display("tb_range_extremum_minimax_product_top: done, errors");
        $finish;
    end

endmodule

>>> range_extremum_minimax_product_top.f
rtl/core/remp_pkg.sv
rtl/core/remp_ram.sv
rtl/core/remp_mul.sv
rtl/core/range_extremum_minimax_product_top.sv
rtl/core/remp_checker.sv
verif/tb_range_extremum_minimax_product_top.sv
